// ===== hw/rtl/wbps_pkg.sv =====
// Shared types and codes for the wildcard byte pattern scanner.
`timescale 1ns / 1ps

package wbps_pkg;

	// Fixed field widths of the beats
	localparam int IDX_W = 5;
	localparam int BYTE_W = 8;
	localparam int LEN_CFG_W = 6;
	localparam int OFF_W = 32;

	// Request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_SCAN = 1'b1;

	// Input beat
	typedef struct packed {
		logic              req_type;
		logic [IDX_W-1:0]  entry_index;
		logic [BYTE_W-1:0] entry_value;
		logic              entry_wild;
		logic [BYTE_W-1:0] data_byte;
		logic              data_last;
	} in_t;

	// Result beat
	typedef struct packed {
		logic             match_found;
		logic [OFF_W-1:0] match_offset;
	} out_t;

	// Control broadcast to every cell of the row
	typedef struct packed {
		logic              shift;
		logic              load;
		logic [BYTE_W-1:0] value;
		logic              wild;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/wbps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wbps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/wbps_cell.sv =====
// One scan cell: a window byte, its aligned pattern entry and the masked compare.
`timescale 1ns / 1ps

module wbps_cell (
	input  logic                              clk,
	input  wbps_pkg::cell_ctl_t               ctl,
	input  logic                              wr_sel,
	input  logic                              use_en,
	input  logic [wbps_pkg::BYTE_W-1:0]       byte_in,
	output logic [wbps_pkg::BYTE_W-1:0]       byte_out,
	output logic                              hit
);

	logic [wbps_pkg::BYTE_W-1:0] win_q;
	logic [wbps_pkg::BYTE_W-1:0] pval_q;
	logic                        pwild_q;

	// Advance the window byte from the neighbour
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			win_q <= byte_in;
		end
	end

	// Hold the pattern entry aligned to this window position
	always_ff @(posedge clk) begin
		if (ctl.load && wr_sel) begin
			pval_q  <= ctl.value;
			pwild_q <= ctl.wild;
		end
	end

	// Compare against the byte that lands here on this shift
	assign hit      = !use_en || pwild_q || (pval_q == byte_in);
	assign byte_out = win_q;

endmodule

// ===== hw/rtl/wildcard_byte_pattern_scan.sv =====
// A result beat is registered from the data beat that causes it and appears in the cycle after that beat is accepted.
// Throughput: one input beat per cycle, loads and scans alike, while the output drains and no realign sweep runs.
// After a pattern_length write the input stalls while one RAM read per cycle
// realigns the stored pattern into the cell row.
// Reset clears the byte count, match flag, output valid and sets length to one;
// pattern and window contents are undefined until written.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan #(
	parameter int MAX_PATTERN = 32,
	parameter int OFFSET_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wbps_pkg::LEN_CFG_W-1:0]      cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  wbps_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output wbps_pkg::out_t                      out_data
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int SW = LEN_W + 1;
	localparam int CW = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;
	localparam int OW = wbps_pkg::OFF_W;
	localparam int BW = wbps_pkg::BYTE_W;

	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       len_wr;
	logic [OFFSET_BITS-1:0] seen_q;
	logic [OFFSET_BITS-1:0] seen_inc;
	logic                   matched_q;
	logic                   swp_act_q;
	logic [LEN_W-1:0]       swp_k_q;
	logic                   rd_v_s1;
	logic [LEN_W-1:0]       rd_k_s1;
	logic                   rd_issue;
	logic                   busy;
	logic                   acc;
	logic                   scan_acc;
	logic                   load_acc;
	logic                   idx_ok;
	logic [BW:0]            ram_rdata;
	logic [LEN_W-1:0]       wpos;
	logic                   wr_any;
	wbps_pkg::cell_ctl_t    ctl;
	logic [MAX_PATTERN-1:0] hit;
	logic [MAX_PATTERN-1:0] wr_sel;
	logic [MAX_PATTERN-1:0] use_en;
	logic [BW-1:0]          chain [MAX_PATTERN+1];
	logic [CW-1:0]          seen_w;
	logic [CW-1:0]          len_w;
	logic [CW-1:0]          diff;
	logic                   found;
	logic                   emit;
	wbps_pkg::out_t         res;
	logic                   out_valid_q;
	wbps_pkg::out_t         out_q;

	// Input handshake
	assign busy     = swp_act_q || rd_v_s1;
	assign in_stall = busy || cfg_wr_en || (out_valid_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign scan_acc = acc && (in_data.req_type == wbps_pkg::REQ_SCAN);
	assign idx_ok   = 32'(in_data.entry_index) < 32'(MAX_PATTERN);
	assign load_acc = acc && (in_data.req_type == wbps_pkg::REQ_LOAD) && idx_ok;

	// Clamp the written length into one to MAX_PATTERN
	always_comb begin
		if (cfg_wr_data == '0) begin
			len_wr = LEN_W'(1);
		end else if (32'(cfg_wr_data) > 32'(MAX_PATTERN)) begin
			len_wr = LEN_W'(MAX_PATTERN);
		end else begin
			len_wr = LEN_W'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg_wr_en) begin
			len_q <= len_wr;
		end
	end

	// Pattern store in entry order
	wbps_ram #(
		.WIDTH(BW + 1),
		.DEPTH(MAX_PATTERN)
	) u_pat_ram (
		.clk  (clk),
		.we   (load_acc),
		.waddr(AW'(in_data.entry_index)),
		.wdata({in_data.entry_wild, in_data.entry_value}),
		.re   (rd_issue),
		.raddr(AW'(swp_k_q)),
		.rdata(ram_rdata)
	);

	// Realign sweep: read entries 0 to len-1 after each length write
	assign rd_issue = swp_act_q && (swp_k_q < len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swp_act_q <= 1'b0;
			swp_k_q   <= '0;
			rd_v_s1   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				swp_act_q <= 1'b1;
				swp_k_q   <= '0;
			end else if (rd_issue) begin
				swp_k_q <= swp_k_q + LEN_W'(1);
			end else begin
				swp_act_q <= 1'b0;
			end
			rd_v_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_k_s1 <= swp_k_q;
	end

	// Cell write: entry k lands in the cell len-1-k
	always_comb begin
		ctl.shift = scan_acc;
		ctl.load  = wr_any;
		if (rd_v_s1) begin
			wpos      = rd_k_s1;
			ctl.value = ram_rdata[BW-1:0];
			ctl.wild  = ram_rdata[BW];
		end else begin
			wpos      = LEN_W'(in_data.entry_index);
			ctl.value = in_data.entry_value;
			ctl.wild  = in_data.entry_wild;
		end
	end

	assign wr_any   = rd_v_s1 || load_acc;
	assign chain[0] = in_data.data_byte;

	// Row of cells; the window shifts from cell to cell
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		assign use_en[j] = SW'(j) < SW'(len_q);
		assign wr_sel[j] = (SW'(j) + SW'(wpos) + SW'(1)) == SW'(len_q);

		wbps_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.wr_sel  (wr_sel[j]),
			.use_en  (use_en[j]),
			.byte_in (chain[j]),
			.byte_out(chain[j+1]),
			.hit     (hit[j])
		);
	end

	// Count bytes of the region, saturating
	assign seen_inc = (seen_q == '1) ? seen_q : seen_q + OFFSET_BITS'(1);
	assign seen_w   = CW'(seen_inc);
	assign len_w    = CW'(len_q);
	assign diff     = seen_w - len_w;
	assign found    = !matched_q && (seen_w >= len_w) && (&hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			matched_q <= 1'b0;
		end else if (scan_acc) begin
			if (in_data.data_last) begin
				seen_q    <= '0;
				matched_q <= 1'b0;
			end else begin
				seen_q    <= seen_inc;
				matched_q <= matched_q || found;
			end
		end
	end

	// Form the result beat
	always_comb begin
		emit = 1'b0;
		res  = '0;
		if (scan_acc) begin
			if (found) begin
				emit             = 1'b1;
				res.match_found  = 1'b1;
				res.match_offset = OW'(diff);
			end else if (in_data.data_last && !matched_q) begin
				emit = 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the wildcard byte pattern scanner.
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_PAT = 32;
	localparam int OFF_BITS = 32;
	localparam int PHASE_ITEMS = 90;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS = 40;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wr_en = 1'b0;
	logic [wbps_pkg::LEN_CFG_W-1:0] cfg_wr_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	wbps_pkg::in_t                  in_data = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	wbps_pkg::out_t                 out_data;

	// Scanner state as the testbench sees it
	logic [wbps_pkg::BYTE_W-1:0]    pat_val [MAX_PAT];
	logic                           pat_wild [MAX_PAT];
	logic [wbps_pkg::BYTE_W-1:0]    win [MAX_PAT];
	logic [wbps_pkg::OFF_W-1:0]     seen_cnt;
	logic                           matched;
	logic [wbps_pkg::LEN_CFG_W-1:0] len_reg;
	wbps_pkg::out_t                 pending_matches [$];

	int errors = 0;
	int items_sent = 0;
	bit tx_gapless = 1'b0;
	bit hold_req = 1'b0;

	wildcard_byte_pattern_scan #(
		.MAX_PATTERN(MAX_PAT),
		.OFFSET_BITS(OFF_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (errors < MAX_REPORTS)
			$display("[%0t] mismatch: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Clamp the length register to the usable range
	function automatic int active_len();
		if (len_reg == 0)
			return 1;
		if (len_reg > MAX_PAT)
			return MAX_PAT;
		return int'(len_reg);
	endfunction

	// Advance the scanner by one accepted beat and queue any result it yields
	function automatic void scan_step(input wbps_pkg::in_t beat);
		int             alen;
		int             k;
		logic           hit;
		wbps_pkg::out_t res;
		if (beat.req_type == wbps_pkg::REQ_LOAD) begin
			pat_val[beat.entry_index] = beat.entry_value;
			pat_wild[beat.entry_index] = beat.entry_wild;
			return;
		end
		for (k = MAX_PAT - 1; k > 0; k--)
			win[k] = win[k - 1];
		win[0] = beat.data_byte;
		if (seen_cnt != '1)
			seen_cnt = seen_cnt + 1'b1;
		alen = active_len();
		if (!matched && seen_cnt >= alen) begin
			hit = 1'b1;
			for (k = 0; k < alen; k++)
				if (!pat_wild[k] && win[alen - 1 - k] != pat_val[k])
					hit = 1'b0;
			if (hit) begin
				matched = 1'b1;
				res.match_found = 1'b1;
				res.match_offset = seen_cnt - alen;
				pending_matches.push_back(res);
			end
		end
		if (beat.data_last) begin
			if (!matched) begin
				res = '0;
				pending_matches.push_back(res);
			end
			seen_cnt = '0;
			matched = 1'b0;
		end
	endfunction

	function automatic wbps_pkg::in_t load_beat(input int idx,
			input logic [wbps_pkg::BYTE_W-1:0] val, input logic wild);
		logic [31:0]   r;
		wbps_pkg::in_t b;
		r = $urandom();
		b = r[$bits(wbps_pkg::in_t)-1:0];
		b.req_type = wbps_pkg::REQ_LOAD;
		b.entry_index = idx[wbps_pkg::IDX_W-1:0];
		b.entry_value = val;
		b.entry_wild = wild;
		return b;
	endfunction

	function automatic wbps_pkg::in_t scan_beat(input logic [wbps_pkg::BYTE_W-1:0] d,
			input logic last);
		logic [31:0]   r;
		wbps_pkg::in_t b;
		r = $urandom();
		b = r[$bits(wbps_pkg::in_t)-1:0];
		b.req_type = wbps_pkg::REQ_SCAN;
		b.data_byte = d;
		b.data_last = last;
		return b;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int idle_gap();
		int roll;
		if (tx_gapless)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	// Offer one beat, hold it until accepted, then update the prediction
	task automatic send_beat(input wbps_pkg::in_t beat);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall !== 1'b0);
		items_sent++;
		scan_step(beat);
	endtask

	// Drop valid and wait for every pending result, plus a margin for silent beats
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(input logic [wbps_pkg::LEN_CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		len_reg = value;
	endtask

	// Send one region, optionally planting the pattern, optionally with one byte spoilt
	task automatic scan_region(input int n_bytes, input bit plant, input bit spoil,
			input bit close_it);
		int                          alen;
		int                          pos;
		int                          bad;
		int                          j;
		int                          i;
		logic [wbps_pkg::BYTE_W-1:0] d;
		alen = active_len();
		pos = -1;
		bad = $urandom_range(0, alen - 1);
		if (plant && n_bytes >= alen) begin
			pos = $urandom_range(0, n_bytes - alen);
			if ($urandom_range(0, 3) == 0)
				pos = n_bytes - alen;
		end
		for (j = 0; j < n_bytes; j++) begin
			d = 8'($urandom());
			if (pos >= 0 && j >= pos && j < pos + alen) begin
				i = j - pos;
				if (!pat_wild[i]) begin
					d = pat_val[i];
					if (spoil && i == bad)
						d = d ^ 8'($urandom_range(1, 255));
				end
			end
			send_beat(scan_beat(d, close_it && j == n_bytes - 1));
		end
	endtask

	task automatic test_pattern_load();
		send_beat(load_beat(0, 8'hA5, 1'b0));
		send_beat(load_beat(1, 8'h00, 1'b0));
		send_beat(load_beat(2, 8'hFF, 1'b0));
		send_beat(load_beat(3, 8'($urandom()), 1'b1));
	endtask

	// Reset length of one: match on the last byte, then a one-byte miss
	task automatic test_single_entry();
		send_beat(scan_beat(8'h11, 1'b0));
		send_beat(scan_beat(8'hA5, 1'b1));
		send_beat(scan_beat(8'h00, 1'b1));
	endtask

	// Four entries with a wildcard: short region, then a match followed by a silent byte
	task automatic test_multi_entry();
		wait_drained();
		write_length(6'd4);
		send_beat(scan_beat(8'hA5, 1'b0));
		send_beat(scan_beat(8'h00, 1'b0));
		send_beat(scan_beat(8'hFF, 1'b1));
		send_beat(scan_beat(8'h33, 1'b0));
		send_beat(scan_beat(8'hA5, 1'b0));
		send_beat(scan_beat(8'h00, 1'b0));
		send_beat(scan_beat(8'hFF, 1'b0));
		send_beat(scan_beat(8'h7E, 1'b0));
		send_beat(scan_beat(8'h01, 1'b1));
	endtask

	// Write a length of zero, which clamps to one, half way through a region
	task automatic test_length_change();
		send_beat(scan_beat(8'hA5, 1'b0));
		send_beat(scan_beat(8'h00, 1'b0));
		wait_drained();
		write_length(6'd0);
		send_beat(scan_beat(8'hA5, 1'b1));
	endtask

	// Hold the result side off while every byte matches, so the input must stall
	task automatic test_backpressure();
		int i;
		wait_drained();
		write_length(6'd1);
		send_beat(load_beat(0, 8'h3C, 1'b1));
		tx_gapless = 1'b1;
		hold_req = 1'b1;
		for (i = 0; i < 40; i++)
			send_beat(scan_beat(8'($urandom()), 1'b1));
		tx_gapless = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_pattern_scan();
		logic [wbps_pkg::LEN_CFG_W-1:0] lengths [8];
		int                             k;
		int                             i;
		int                             n;
		int                             roll;
		int                             alen;
		int                             start;
		lengths = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd33, 6'd2, 6'd17, 6'd5};
		for (i = 0; i < MAX_PAT; i++)
			send_beat(load_beat(i, 8'($urandom()), $urandom_range(0, 3) == 0));
		for (k = 0; k < 12; k++) begin
			wait_drained();
			write_length(k < 8 ? lengths[k] : wbps_pkg::LEN_CFG_W'($urandom()));
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0)
					tx_gapless = !tx_gapless;
				roll = $urandom_range(0, 99);
				alen = active_len();
				if (roll < 12) begin
					n = $urandom_range(1, 3);
					repeat (n)
						send_beat(load_beat($urandom_range(0, MAX_PAT - 1), 8'($urandom()),
							$urandom_range(0, 3) == 0));
				end else if (roll < 17) begin
					wait_drained();
				end else if (roll < 62) begin
					scan_region(alen + $urandom_range(0, 10), 1'b1, 1'b0, 1'b1);
				end else if (roll < 75) begin
					scan_region(alen + $urandom_range(0, 10), 1'b1, 1'b1, 1'b1);
				end else if (roll < 85) begin
					scan_region($urandom_range(1, alen > 1 ? alen - 1 : 1), 1'b0, 1'b0, 1'b1);
				end else begin
					scan_region($urandom_range(1, 24), 1'b0, 1'b0, 1'b1);
				end
			end
			// Leave a region open across the next length change now and then
			if ($urandom_range(0, 1) == 1)
				scan_region($urandom_range(1, 6), 1'b1, 1'b0, 1'b0);
		end
		tx_gapless = 1'b0;
	endtask

	initial begin
		seen_cnt = '0;
		matched = 1'b0;
		len_reg = 6'd1;
		foreach (win[k]) begin
			win[k] = '0;
			pat_val[k] = '0;
			pat_wild[k] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pattern_load();
		test_single_entry();
		test_multi_entry();
		test_length_change();
		test_backpressure();
		test_random_pattern_scan();
		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Pace the result side: random stalls, free stretches, and one long hold on request
	always @(posedge clk) begin : rx_pacing
		int hold_left;
		int rx_left;
		int roll;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 150;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (rx_left > 0) begin
			rx_left = rx_left - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				out_stall <= 1'b0;
				rx_left = $urandom_range(0, 8);
			end else if (roll < 85) begin
				out_stall <= 1'b1;
				rx_left = $urandom_range(0, 2);
			end else if (roll < 97) begin
				out_stall <= 1'b1;
				rx_left = $urandom_range(3, 10);
			end else begin
				out_stall <= 1'b0;
				rx_left = $urandom_range(30, 80);
			end
		end
	end

	// Compare each accepted result beat with the oldest pending one
	always @(posedge clk) begin : result_check
		wbps_pkg::out_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_matches.size() == 0) begin
				report_mismatch("result beat with none pending, offset", out_data.match_offset, 0);
			end else begin
				want = pending_matches.pop_front();
				if (out_data.match_found !== want.match_found)
					report_mismatch("match_found", out_data.match_found, want.match_found);
				if (out_data.match_offset !== want.match_offset)
					report_mismatch("match_offset", out_data.match_offset, want.match_offset);
			end
		end
	end

	// End the run if neither side moves a beat for too long
	always @(posedge clk) begin : watchdog
		int quiet;
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("[%0t] no beat accepted for %0d cycles", $realtime, quiet);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_ram.sv
hw/rtl/wbps_cell.sv
hw/rtl/wildcard_byte_pattern_scan.sv
sim/tb_top.sv
